/* rtl/core/double_ended_queue_unit_macros.svh */
// ----------------------------------------------------------------------------
// Double-ended queue unit assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DEQU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DEQU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

/* rtl/core/dequ_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Field widths, operation and status codes, and the cell command type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dequ_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int PORT_DATA_WIDTH = 32;
   localparam int OPCODE_WIDTH    = 2;
   localparam int INDEX_WIDTH     = 6;
   localparam int STATUS_WIDTH    = 2;
   localparam int LENGTH_WIDTH    = 7;

   localparam logic [OPCODE_WIDTH-1:0] OP_PUT    = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_GET    = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_READ   = 2'd2;
   localparam logic [OPCODE_WIDTH-1:0] OP_REMOVE = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE     = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic shift_in;
      logic shift_out;
      logic write;
      logic remove;
   } dequ_cmd_type;

endpackage

/* rtl/core/double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// Double-ended queue unit
// A bounded double-ended queue of data words held in a chain of cells.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (opcode, end_select, data_in, index) and
// each one produces exactly one item on the rsp_ channel (data_out, status,
// length). Both channels use a valid/ready handshake.
// An accepted item passes through four internal steps: scan (every cell
// compares its entry and decodes the target position), pick (the first match
// from the chosen end is isolated and the read bus is sampled), apply (the
// cells shift or write and the length is updated) and output. A new request is
// taken only in the idle state, after the previous result has been loaded
// into the output register. Insertion or removal at the head shifts the
// whole chain, and removal of a matched word shifts each cell from the
// match onward, so every operation passes through the same steps.
// Reset empties the queue and drops any pending result; cell contents are not
// cleared. When the receiver stalls, the finished result waits in the output
// register while the next request may already be accepted and worked on; that
// request then waits until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit
   import dequ_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_WIDTH-1:0]    req_opcode,
   input  logic                       req_end_select,
   input  logic [PORT_DATA_WIDTH-1:0] req_data_in,
   input  logic [INDEX_WIDTH-1:0]     req_index,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PORT_DATA_WIDTH-1:0] rsp_data_out,
   output logic [STATUS_WIDTH-1:0]    rsp_status,
   output logic [LENGTH_WIDTH-1:0]    rsp_length
);

   localparam int CW         = $clog2(DEPTH + 1);
   localparam int WORD_WIDE  = (DATA_WIDTH > PORT_DATA_WIDTH) ? DATA_WIDTH : PORT_DATA_WIDTH;
   localparam int LEN_WIDE   = (CW > LENGTH_WIDTH) ? CW : LENGTH_WIDTH;
   localparam int IDX_WIDE   = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_PICK  = 3'd2;
   localparam logic [2:0] S_APPLY = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   logic [2:0]                state_ff;
   logic [2:0]                state_in;
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             count_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;

   logic [OPCODE_WIDTH-1:0]   op_ff;
   logic                      tail_ff;
   logic [DATA_WIDTH-1:0]     word_ff;
   logic [CW-1:0]             target_ff;
   logic                      error_ff;
   logic [DEPTH-1:0]          sel_ff;
   logic [DEPTH-1:0]          match_ff;
   logic [DEPTH-1:0]          mask_ff;
   logic                      found_ff;
   logic [DATA_WIDTH-1:0]     rd_ff;
   logic [DATA_WIDTH-1:0]     res_data_ff;
   logic [STATUS_WIDTH-1:0]   res_status_ff;
   logic [CW-1:0]             res_count_ff;
   logic [DATA_WIDTH-1:0]     rsp_data_ff;
   logic [STATUS_WIDTH-1:0]   rsp_status_ff;
   logic [CW-1:0]             rsp_count_ff;

   logic                      accept;
   logic                      rsp_load;
   logic [WORD_WIDE-1:0]      req_word_wide;
   logic [DATA_WIDTH-1:0]     req_word;
   logic [IDX_WIDE-1:0]       idx_wide;
   logic [IDX_WIDE-1:0]       count_wide;
   logic [IDX_WIDE-1:0]       tail_pos;
   logic [CW-1:0]             req_target;
   logic                      req_error;
   logic [CW-1:0]             count_less;

   dequ_cmd_type              cmd;
   logic [DEPTH-1:0]          match_vec;
   logic [DEPTH-1:0]          sel_vec;
   logic [DATA_WIDTH-1:0]     read_data;

   logic [DEPTH-1:0]          search_vec;
   logic [DEPTH-1:0]          neg_vec;
   logic [DEPTH-1:0]          iso_vec;
   logic [DEPTH-1:0]          from_vec;
   logic [DEPTH-1:0]          mask_dir;
   logic [DEPTH-1:0]          mask_vec;

   logic [DATA_WIDTH-1:0]     res_data;
   logic [STATUS_WIDTH-1:0]   res_status;
   logic [WORD_WIDE-1:0]      out_wide;
   logic [LEN_WIDE-1:0]       len_wide;

   // Request decode: the target position is counted from the head.
   assign req_ready     = (state_ff == S_IDLE);
   assign accept        = req_valid && req_ready;
   assign req_word_wide = WORD_WIDE'(req_data_in);
   assign req_word      = req_word_wide[DATA_WIDTH-1:0];
   assign idx_wide      = IDX_WIDE'(req_index);
   assign count_wide    = IDX_WIDE'(count_ff);
   assign tail_pos      = count_wide - idx_wide - IDX_WIDE'(1);
   assign count_less    = count_ff - CW'(1);

   always_comb begin
      unique case (req_opcode)
         OP_PUT: begin
            req_target = count_ff;
            req_error  = (count_ff == CW'(DEPTH));
         end
         OP_GET: begin
            req_target = req_end_select ? count_less : '0;
            req_error  = (count_ff == '0);
         end
         OP_READ: begin
            req_target = req_end_select ? tail_pos[CW-1:0] : idx_wide[CW-1:0];
            req_error  = (idx_wide >= count_wide);
         end
         default: begin
            req_target = '0;
            req_error  = 1'b0;
         end
      endcase
   end

   // First match from the chosen end and the mask of cells at or above it.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         search_vec[i] = tail_ff ? match_ff[DEPTH-1-i] : match_ff[i];
      end
      neg_vec  = ~search_vec + DEPTH'(1);
      iso_vec  = search_vec & neg_vec;
      from_vec = search_vec | neg_vec;
      mask_dir = tail_ff ? (~from_vec | iso_vec) : from_vec;
      for (int i = 0; i < DEPTH; i++) begin
         mask_vec[i] = tail_ff ? mask_dir[DEPTH-1-i] : mask_dir[i];
      end
   end

   always_comb begin
      cmd = '0;
      if (state_ff == S_APPLY) begin
         cmd.shift_in  = (op_ff == OP_PUT) && !tail_ff && !error_ff;
         cmd.shift_out = (op_ff == OP_GET) && !tail_ff && !error_ff;
         cmd.write     = (op_ff == OP_PUT) && tail_ff && !error_ff;
         cmd.remove    = (op_ff == OP_REMOVE) && found_ff;
      end
   end

   dequ_chain #(
      .DEPTH       (DEPTH),
      .DATA_WIDTH  (DATA_WIDTH),
      .COUNT_WIDTH (CW)
   ) u_chain (
      .clock       (clock),
      .cmd         (cmd),
      .remove_mask (mask_ff),
      .read_mask   (sel_ff),
      .count       (count_ff),
      .target      (target_ff),
      .word        (word_ff),
      .match_vec   (match_vec),
      .sel_vec     (sel_vec),
      .read_data   (read_data)
   );

   always_comb begin
      res_data   = '0;
      res_status = STATUS_OK;
      unique case (op_ff)
         OP_PUT: begin
            if (error_ff) begin
               res_status = STATUS_FULL;
            end
         end
         OP_GET, OP_READ: begin
            if (error_ff) begin
               res_status = STATUS_RANGE;
            end else begin
               res_data = rd_ff;
            end
         end
         default: begin
            if (found_ff) begin
               res_data = word_ff;
            end else begin
               res_status = STATUS_NOT_FOUND;
            end
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.shift_in || cmd.write) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.shift_out || cmd.remove ||
                   ((state_ff == S_APPLY) && (op_ff == OP_GET) && !error_ff)) begin
         count_in = count_less;
      end
   end

   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_SCAN : S_IDLE;
         S_SCAN:  state_in = S_PICK;
         S_PICK:  state_in = S_APPLY;
         S_APPLY: state_in = S_OUT;
         S_OUT:   state_in = rsp_load ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_opcode;
         tail_ff   <= req_end_select;
         word_ff   <= req_word;
         target_ff <= req_target;
         error_ff  <= req_error;
      end
      if (state_ff == S_SCAN) begin
         sel_ff   <= sel_vec;
         match_ff <= match_vec;
      end
      if (state_ff == S_PICK) begin
         mask_ff  <= mask_vec;
         found_ff <= (match_ff != '0);
         rd_ff    <= read_data;
      end
      if (state_ff == S_APPLY) begin
         res_data_ff   <= res_data;
         res_status_ff <= res_status;
         res_count_ff  <= count_in;
      end
      if (rsp_load) begin
         rsp_data_ff   <= res_data_ff;
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   assign out_wide     = WORD_WIDE'(rsp_data_ff);
   assign len_wide     = LEN_WIDE'(rsp_count_ff);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = out_wide[PORT_DATA_WIDTH-1:0];
   assign rsp_status   = rsp_status_ff;
   assign rsp_length   = len_wide[LENGTH_WIDTH-1:0];

   `DEQU_ASSERT_NEXT(a_count_hold, state_ff != S_APPLY, count_ff == $past(count_ff))
   `DEQU_ASSERT_NEXT(a_remove_shrinks, cmd.remove, count_ff == $past(count_less))
   `DEQU_ASSERT_NEXT(a_accept_scan, accept, state_ff == S_SCAN)
   `DEQU_ASSERT_SAME(a_remove_found, cmd.remove, (mask_ff != '0) && (match_ff != '0))

endmodule

/* rtl/core/dequ_cell.sv */
// ----------------------------------------------------------------------------
// Double-ended queue cell
// Holds the entry at one position counted from the head and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dequ_cell
   import dequ_pkg::*;
#(
   parameter int DATA_WIDTH  = DATA_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = 7,
   parameter int CELL_INDEX  = 0
) (
   input  logic                   clock,
   input  dequ_cmd_type           cmd,
   input  logic                   remove_en,
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [COUNT_WIDTH-1:0] target,
   input  logic [DATA_WIDTH-1:0]  word,
   input  logic [DATA_WIDTH-1:0]  left_data,
   input  logic [DATA_WIDTH-1:0]  right_data,
   output logic [DATA_WIDTH-1:0]  data,
   output logic                   hit,
   output logic                   sel
);

   localparam logic [COUNT_WIDTH-1:0] POSITION = COUNT_WIDTH'(CELL_INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   assign sel  = (target == POSITION);
   assign hit  = (POSITION < count) && (data_ff == word);
   assign data = data_ff;

   always_comb begin
      priority if (cmd.shift_in) begin
         data_in = left_data;
      end else if (cmd.shift_out || (cmd.remove && remove_en)) begin
         data_in = right_data;
      end else if (cmd.write && sel) begin
         data_in = word;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

/* rtl/core/dequ_chain.sv */
// ----------------------------------------------------------------------------
// Double-ended queue cell chain
// A row of cells, each passing its entry to either neighbor, with a read bus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dequ_chain
   import dequ_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int DATA_WIDTH  = DATA_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = 7
) (
   input  logic                   clock,
   input  dequ_cmd_type           cmd,
   input  logic [DEPTH-1:0]       remove_mask,
   input  logic [DEPTH-1:0]       read_mask,
   input  logic [COUNT_WIDTH-1:0] count,
   input  logic [COUNT_WIDTH-1:0] target,
   input  logic [DATA_WIDTH-1:0]  word,
   output logic [DEPTH-1:0]       match_vec,
   output logic [DEPTH-1:0]       sel_vec,
   output logic [DATA_WIDTH-1:0]  read_data
);

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic [DATA_WIDTH-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = word;
      end else begin : g_inner_left
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner_right
         assign right_data = cell_data[i+1];
      end

      dequ_cell #(
         .DATA_WIDTH  (DATA_WIDTH),
         .COUNT_WIDTH (COUNT_WIDTH),
         .CELL_INDEX  (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .remove_en  (remove_mask[i]),
         .count      (count),
         .target     (target),
         .word       (word),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .hit        (match_vec[i]),
         .sel        (sel_vec[i])
      );
   end

   always_comb begin
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_data = read_data | (cell_data[i] & {DATA_WIDTH{read_mask[i]}});
      end
   end

endmodule
